FILE: src/cmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmp_pkg
// Types, constants and tables for the compass heading and needle core.
// ----------------------------------------------------------------------------
package cmp_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_STAGES_MAX = 24;

  // CORDIC vector width: 17-bit magnitude, scaled by 2^8, gain and headroom
  localparam int VW = 28;
  // angle width in 1/256 degree
  localparam int ZW = 18;

  localparam int ANG_UNIT  = 256;
  localparam int FULL_TURN = 360 * ANG_UNIT;
  localparam int QTR_TURN  = 90 * ANG_UNIT;
  localparam int HALF_TURN = 180 * ANG_UNIT;

  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_NOSAMPLE = 2'd2;

  localparam logic REG_CENTER = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  localparam logic [6:0] CENTER_RST = 7'd80;
  localparam logic [6:0] LENGTH_RST = 7'd60;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           status;
  } cmp_vec_t;

  // Q1.14 sine of whole degrees 0..90
  localparam logic [14:0] SIN_TAB [0:90] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
    15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
    15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
    15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
    15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
    15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // atan(2^-i) in 1/256 degree
  function automatic int atan_ang(input int i);
    int r;
    case (i)
      0:       r = 11520;
      1:       r = 6801;
      2:       r = 3593;
      3:       r = 1824;
      4:       r = 916;
      5:       r = 458;
      6:       r = 229;
      7:       r = 115;
      8:       r = 57;
      9:       r = 29;
      10:      r = 14;
      11:      r = 7;
      12:      r = 4;
      13:      r = 2;
      14:      r = 1;
      default: r = 0;
    endcase
    return r;
  endfunction

  // sine of a whole-degree angle 0..359, Q1.14
  function automatic logic signed [15:0] sin_deg(input logic [8:0] h);
    logic [6:0]  idx;
    logic        neg;
    logic [15:0] mag;
    if (h <= 9'd90) begin
      idx = h[6:0];
      neg = 1'b0;
    end else if (h <= 9'd180) begin
      idx = 7'(9'd180 - h);
      neg = 1'b0;
    end else if (h <= 9'd270) begin
      idx = 7'(h - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - h);
      neg = 1'b1;
    end
    mag = {1'b0, SIN_TAB[idx]};
    return neg ? -signed'(mag) : signed'(mag);
  endfunction

endpackage
`default_nettype wire

FILE: src/cmp_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmp_prep
// Input stage: status decode, left half-plane fold, axis cases, 2^8 scaling.
// ----------------------------------------------------------------------------
module cmp_prep (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire signed [15:0]    mag_x,
  input  wire signed [15:0]    mag_y,
  input  wire                  sensor_on,
  input  wire                  sample_present,
  output logic                 out_valid,
  input  wire                  out_ready,
  output cmp_pkg::cmp_vec_t    out_data
);
  import cmp_pkg::*;

  logic                 valid;
  cmp_vec_t             data;
  cmp_vec_t             data_next;
  logic signed [VW-1:0] xe;
  logic signed [VW-1:0] ye;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    xe = VW'(mag_x);
    ye = VW'(mag_y);
    data_next.status = !sensor_on ? ST_DISABLED :
                       (!sample_present ? ST_NOSAMPLE : ST_VALID);
    if (xe == '0) begin
      // exact axis: a zero y keeps every cell idle
      data_next.x = '0;
      data_next.y = '0;
      if (ye > 0)      data_next.z = ZW'(QTR_TURN);
      else if (ye < 0) data_next.z = -ZW'(QTR_TURN);
      else             data_next.z = '0;
    end else if (xe < 0) begin
      data_next.x = (-xe) <<< 8;
      data_next.y = (-ye) <<< 8;
      data_next.z = ZW'(HALF_TURN);
    end else begin
      data_next.x = xe <<< 8;
      data_next.y = ye <<< 8;
      data_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/cmp_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmp_cell
// One vectoring CORDIC rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module cmp_cell #(
  parameter int STAGE = 0
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  cmp_pkg::cmp_vec_t    in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output cmp_pkg::cmp_vec_t    out_data
);
  import cmp_pkg::*;

  localparam logic signed [ZW-1:0] ANG = ZW'(atan_ang(STAGE));

  logic                 valid;
  cmp_vec_t             data;
  cmp_vec_t             data_next;
  logic signed [VW-1:0] xs;
  logic signed [VW-1:0] ys;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    xs = in_data.x;
    ys = in_data.y;
    data_next = in_data;
    if (ys > 0) begin
      data_next.x = xs + (ys >>> STAGE);
      data_next.y = ys - (xs >>> STAGE);
      data_next.z = in_data.z + ANG;
    end else if (ys < 0) begin
      data_next.x = xs - (ys >>> STAGE);
      data_next.y = ys + (xs >>> STAGE);
      data_next.z = in_data.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/cmp_post.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmp_post
// Heading from angle, cardinal index, sine lookup and needle tip, 3 stages.
// ----------------------------------------------------------------------------
module cmp_post (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  cmp_pkg::cmp_vec_t    in_data,
  input  wire [6:0]            needle_center,
  input  wire [6:0]            needle_length,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [1:0]           status,
  output logic [8:0]           heading,
  output logic [2:0]           cardinal,
  output logic signed [8:0]    tip_x,
  output logic signed [8:0]    tip_y
);
  import cmp_pkg::*;

  logic v1, v2, v3;
  logic r1, r2, r3;

  logic [1:0] st1, st2;
  logic [8:0] h1, h2;
  logic [2:0] card2;
  logic signed [15:0] sn2, cs2;

  logic signed [ZW-1:0] aw;
  logic signed [ZW-1:0] d;
  logic [ZW-1:0]        dmag;
  logic [8:0]           q;
  logic [8:0]           h_next;

  logic [9:0]  hc;
  logic [8:0]  hcw;
  logic [8:0]  cv;
  logic [2:0]  card_next;

  logic signed [23:0] px, py;
  logic signed [8:0]  qx, qy;
  logic signed [9:0]  tx, ty;

  assign r3 = !v3 || out_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready  = r1;
  assign out_valid = v3;

  // stage 1: wrap to [0,360), subtract from 90, truncate, wrap
  always_comb begin
    aw = (in_data.z < 0) ? in_data.z + ZW'(FULL_TURN) : in_data.z;
    d  = ZW'(QTR_TURN) - aw;
    dmag = (d < 0) ? ZW'(-d) : ZW'(d);
    q = 9'(dmag >> 8);
    if (in_data.status != ST_VALID) begin
      h_next = '0;
    end else if (d < 0) begin
      h_next = (q == '0) ? 9'd0 : 9'(9'd360 - q);
    end else begin
      h_next = q;
    end
  end

  // stage 2: sine, cosine and cardinal
  always_comb begin
    hc  = {1'b0, h1} + 10'd90;
    hcw = (hc >= 10'd360) ? 9'(hc - 10'd360) : hc[8:0];
    cv  = (h1 + 9'd22 >= 9'd360) ? 9'(h1 + 9'd22 - 9'd360) : 9'(h1 + 9'd22);
    if (cv >= 9'd315)      card_next = 3'd7;
    else if (cv >= 9'd270) card_next = 3'd6;
    else if (cv >= 9'd225) card_next = 3'd5;
    else if (cv >= 9'd180) card_next = 3'd4;
    else if (cv >= 9'd135) card_next = 3'd3;
    else if (cv >= 9'd90)  card_next = 3'd2;
    else if (cv >= 9'd45)  card_next = 3'd1;
    else                   card_next = 3'd0;
  end

  // stage 3: length times sine and cosine, truncated toward zero, plus center
  always_comb begin
    px = signed'({1'b0, needle_length}) * sn2;
    py = signed'({1'b0, needle_length}) * cs2;
    qx = (px < 0) ? -9'((-px) >>> 14) : 9'(px >>> 14);
    qy = (py < 0) ? -9'((-py) >>> 14) : 9'(py >>> 14);
    tx = signed'({3'b000, needle_center}) + 10'(qx);
    ty = signed'({3'b000, needle_center}) - 10'(qy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      st1 <= in_data.status;
      h1  <= h_next;
    end
    if (r2 && v1) begin
      st2   <= st1;
      h2    <= h1;
      card2 <= card_next;
      sn2   <= sin_deg(h1);
      cs2   <= sin_deg(hcw);
    end
    if (r3 && v2) begin
      status   <= st2;
      heading  <= h2;
      cardinal <= card2;
      tip_x    <= tx[8:0];
      tip_y    <= ty[8:0];
    end
  end

endmodule
`default_nettype wire

FILE: src/compass_heading_and_needle_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// compass_heading_and_needle_core
// Magnetometer X/Y to compass heading, cardinal index and needle tip.
//
// channel  dir  handshake          payload
// s_       in   tvalid/tready      tdata mag_x,mag_y; tuser sensor_on,sample_present
// m_       out  tvalid/tready      tdata heading,cardinal,tip_x,tip_y; tuser status
// apb      in   psel/penable       needle_center @0x0, needle_length @0x4
//
// One request per cycle unless the output stalls. Input stage, one cell per
// CORDIC rotation, then heading, table lookup and needle multiply.
// Each stage holds its own valid bit, so bubbles close up under stall.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module compass_heading_and_needle_core #(
  parameter int CORDIC_STAGES = cmp_pkg::CORDIC_STAGES_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // mag_x[15:0], mag_y[31:16]
  input  wire  [1:0]  s_tuser,   // sensor_on[0], sample_present[1]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // heading[8:0], cardinal[11:9], tip_x[20:12],
                                 // tip_y[29:21], zero[31:30]
  output logic [1:0]  m_tuser,   // status[1:0]
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cmp_pkg::*;

  logic [6:0] needle_center;
  logic [6:0] needle_length;

  logic        vld [0:CORDIC_STAGES];
  logic        rdy [0:CORDIC_STAGES];
  cmp_vec_t    vec [0:CORDIC_STAGES];

  logic [1:0]        status;
  logic [8:0]        heading;
  logic [2:0]        cardinal;
  logic signed [8:0] tip_x;
  logic signed [8:0] tip_y;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_center <= CENTER_RST;
      needle_length <= LENGTH_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_CENTER: needle_center <= pwdata[6:0];
        REG_LENGTH: needle_length <= pwdata[6:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CENTER: prdata = {25'd0, needle_center};
      REG_LENGTH: prdata = {25'd0, needle_length};
      default:    prdata = '0;
    endcase
  end

  cmp_prep u_prep (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .mag_x          (s_tdata[15:0]),
    .mag_y          (s_tdata[31:16]),
    .sensor_on      (s_tuser[0]),
    .sample_present (s_tuser[1]),
    .out_valid      (vld[0]),
    .out_ready      (rdy[0]),
    .out_data       (vec[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    cmp_cell #(
      .STAGE (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_data   (vec[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_data  (vec[i+1])
    );
  end

  cmp_post u_post (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (vld[CORDIC_STAGES]),
    .in_ready      (rdy[CORDIC_STAGES]),
    .in_data       (vec[CORDIC_STAGES]),
    .needle_center (needle_center),
    .needle_length (needle_length),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .status        (status),
    .heading       (heading),
    .cardinal      (cardinal),
    .tip_x         (tip_x),
    .tip_y         (tip_y)
  );

  assign m_tdata = {2'b00, tip_y, tip_x, cardinal, heading};
  assign m_tuser = status;

endmodule
`default_nettype wire

FILE: bench/compass_heading_and_needle_core_test.sv
// ----------------------------------------------------------------------------
// compass_heading_and_needle_core_test
// Self-checking bench for the compass heading and needle core.
//
// Walks a short table of directed samples (disabled sensor, missing sample,
// zero vector, axes, diagonals, field extremes), then random samples over
// several needle center/length settings. Each accepted request takes its
// expectation from its table row if typed, else from a local CORDIC/sine
// predictor; it is queued and compared field by field with the next accepted
// result. Both stream sides idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module compass_heading_and_needle_core_test;
  import cmp_pkg::*;

  localparam int STAGES  = CORDIC_STAGES_DEF;
  localparam int LAT     = STAGES + 4;
  localparam int PER_SET = 130;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] heading;
    logic [2:0] cardinal;
    logic [8:0] tip_x;
    logic [8:0] tip_y;
  } needle_rec_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               sensor_on;
    logic               sample_present;
    logic               typed;
    needle_rec_t        want;
  } sample_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  needle_rec_t expected_q [$];
  int          mismatch_count = 0;
  int          center_cfg = 80;
  int          length_cfg = 60;
  bit          calm = 1'b0;
  int          stall_left = 0;

  int atan_step [24] = '{11520, 6801, 3593, 1824, 916, 458, 229, 115, 57, 29, 14, 7,
                         4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  int sine_q14 [91] = '{
    0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
    2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
    5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
    8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384};

  sample_row_t directed_rows [24] = '{
    '{16'sd1234, -16'sd567, 1'b0, 1'b1, 1'b1, '{ST_DISABLED, 9'd0, 3'd0, 9'd80, 9'd20}},
    '{16'sd1234, -16'sd567, 1'b1, 1'b0, 1'b1, '{ST_NOSAMPLE, 9'd0, 3'd0, 9'd80, 9'd20}},
    '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1, '{ST_DISABLED, 9'd0, 3'd0, 9'd80, 9'd20}},
    '{16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1, '{ST_VALID, 9'd90, 3'd2, 9'd140, 9'd80}},
    '{16'sd0, 16'sd100, 1'b1, 1'b1, 1'b1, '{ST_VALID, 9'd0, 3'd0, 9'd80, 9'd20}},
    '{16'sd0, -16'sd100, 1'b1, 1'b1, 1'b1, '{ST_VALID, 9'd180, 3'd4, 9'd80, 9'd140}},
    '{16'sd100, 16'sd0, 1'b1, 1'b1, 1'b1, '{ST_VALID, 9'd90, 3'd2, 9'd140, 9'd80}},
    '{-16'sd100, 16'sd0, 1'b1, 1'b1, 1'b1, '{ST_VALID, 9'd270, 3'd6, 9'd20, 9'd80}},
    '{16'sd32767, 16'sd0, 1'b1, 1'b1, 1'b1, '{ST_VALID, 9'd90, 3'd2, 9'd140, 9'd80}},
    '{16'sh8000, 16'sd0, 1'b1, 1'b1, 1'b1, '{ST_VALID, 9'd270, 3'd6, 9'd20, 9'd80}},
    '{16'sd0, 16'sd32767, 1'b1, 1'b1, 1'b1, '{ST_VALID, 9'd0, 3'd0, 9'd80, 9'd20}},
    '{16'sd0, 16'sh8000, 1'b1, 1'b1, 1'b1, '{ST_VALID, 9'd180, 3'd4, 9'd80, 9'd140}},
    '{-16'sd1, 16'sd0, 1'b1, 1'b1, 1'b1, '{ST_VALID, 9'd270, 3'd6, 9'd20, 9'd80}},
    '{16'sd100, 16'sd100, 1'b1, 1'b1, 1'b0, '0},
    '{-16'sd100, 16'sd100, 1'b1, 1'b1, 1'b0, '0},
    '{-16'sd100, -16'sd100, 1'b1, 1'b1, 1'b0, '0},
    '{16'sd100, -16'sd100, 1'b1, 1'b1, 1'b0, '0},
    '{16'sd32767, 16'sd32767, 1'b1, 1'b1, 1'b0, '0},
    '{16'sh8000, 16'sh8000, 1'b1, 1'b1, 1'b0, '0},
    '{16'sd32767, 16'sh8000, 1'b1, 1'b1, 1'b0, '0},
    '{16'sh8000, 16'sd32767, 1'b1, 1'b1, 1'b0, '0},
    '{16'sd1, 16'sd1, 1'b1, 1'b1, 1'b0, '0},
    '{16'sd1, -16'sd1, 1'b1, 1'b1, 1'b0, '0},
    '{16'sd12345, -16'sd23456, 1'b1, 1'b1, 1'b0, '0}
  };

  compass_heading_and_needle_core #(.CORDIC_STAGES(STAGES)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // atan2(y,x) in 1/256 degree by vectoring rotations
  function automatic int field_angle(int xi, int yi);
    longint x, y, nx, ny;
    int     z;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0) begin
      if (y > 0) return QTR_TURN;
      if (y < 0) return -QTR_TURN;
      return 0;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      if (y != 0) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z = z + atan_step[i];
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z = z - atan_step[i];
        end
        x = nx;
        y = ny;
      end
    end
    return z;
  endfunction

  function automatic int compass_heading(int x, int y);
    int a, d, whole;
    a = field_angle(x, y);
    while (a < 0) a = a + FULL_TURN;
    while (a >= FULL_TURN) a = a - FULL_TURN;
    d = QTR_TURN - a;
    whole = d / ANG_UNIT;  // truncates toward zero
    while (whole < 0) whole = whole + 360;
    while (whole >= 360) whole = whole - 360;
    return whole;
  endfunction

  function automatic int sine_of_deg(int deg);
    int h;
    h = deg % 360;
    if (h <= 90) return sine_q14[h];
    if (h <= 180) return sine_q14[180 - h];
    if (h <= 270) return -sine_q14[h - 180];
    return -sine_q14[360 - h];
  endfunction

  function automatic needle_rec_t predict_needle(logic signed [15:0] mx,
                                                 logic signed [15:0] my,
                                                 logic [1:0] user);
    needle_rec_t r;
    int          h, tx, ty;
    h = 0;
    if (!user[0]) r.status = ST_DISABLED;
    else if (!user[1]) r.status = ST_NOSAMPLE;
    else r.status = ST_VALID;
    if (r.status == ST_VALID) h = compass_heading(int'(mx), int'(my));
    tx = center_cfg + (length_cfg * sine_of_deg(h)) / 16384;
    ty = center_cfg - (length_cfg * sine_of_deg(h + 90)) / 16384;
    r.heading  = 9'(h);
    r.cardinal = 3'(((h + 22) % 360) / 45);
    r.tip_x    = 9'(tx);
    r.tip_y    = 9'(ty);
    return r;
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    needle_rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        note_mismatch("result with no request pending, heading", m_tdata[8:0], -1);
      end else begin
        want = expected_q.pop_front();
        if (m_tuser != want.status)
          note_mismatch("status", m_tuser, want.status);
        if (m_tdata[8:0] != want.heading)
          note_mismatch("heading", m_tdata[8:0], want.heading);
        if (m_tdata[11:9] != want.cardinal)
          note_mismatch("cardinal", m_tdata[11:9], want.cardinal);
        if (m_tdata[20:12] != want.tip_x)
          note_mismatch("tip_x", $signed(m_tdata[20:12]), $signed(want.tip_x));
        if (m_tdata[29:21] != want.tip_y)
          note_mismatch("tip_y", $signed(m_tdata[29:21]), $signed(want.tip_y));
      end
    end
  end

  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [1:0] user,
                             bit typed, needle_rec_t typed_want);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    s_tuser  <= user;
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(typed ? typed_want : predict_needle(x, y, user));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic write_reg(logic sel, logic [6:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {25'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (sel == REG_CENTER) center_cfg = int'(val);
    else length_cfg = int'(val);
  endtask

  task automatic pick_sample(output logic [15:0] x, output logic [15:0] y,
                             output logic [1:0] user);
    int vx, vy, m;
    int ext [6];
    ext = '{-32768, -32767, -1, 0, 1, 32767};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        vx = int'($urandom_range(0, 65535)) - 32768;
        vy = int'($urandom_range(0, 65535)) - 32768;
      end
      4: begin
        vx = int'($urandom_range(0, 6)) - 3;
        vy = int'($urandom_range(0, 6)) - 3;
      end
      5: begin
        vx = int'($urandom_range(0, 65535)) - 32768;
        vy = int'($urandom_range(0, 65535)) - 32768;
        if ($urandom_range(0, 1) != 0) vx = 0;
        else vy = 0;
      end
      6: begin
        m  = $urandom_range(1, 32767);
        vx = ($urandom_range(0, 1) != 0) ? m : -m;
        vy = ($urandom_range(0, 1) != 0) ? m : -m;
      end
      7: begin
        vx = ext[$urandom_range(0, 5)];
        vy = ext[$urandom_range(0, 5)];
      end
      8: begin
        vx = int'($urandom_range(0, 65535)) - 32768;
        vy = int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) != 0) begin
          m  = vx;
          vx = vy;
          vy = m;
        end
      end
      default: begin
        vx = int'($urandom_range(0, 510)) - 255;
        vy = int'($urandom_range(0, 510)) - 255;
      end
    endcase
    x    = 16'(vx);
    y    = 16'(vy);
    user = ($urandom_range(0, 9) < 8) ? 2'b11 : 2'($urandom_range(0, 3));
  endtask

  initial begin
    logic [15:0] x, y;
    logic [1:0]  user;
    int          set_center [7];
    int          set_length [7];
    set_center = '{80, 0, 127, 0, 127, 0, 0};
    set_length = '{60, 0, 127, 127, 0, 0, 0};
    set_center[5] = $urandom_range(0, 127);
    set_length[5] = $urandom_range(0, 127);
    set_center[6] = $urandom_range(0, 127);
    set_length[6] = $urandom_range(0, 127);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_sample(directed_rows[i].x, directed_rows[i].y,
                  {directed_rows[i].sample_present, directed_rows[i].sensor_on},
                  directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < 7; p++) begin
      if (p != 0) begin
        drain_results();
        if (p == 6) calm = 1'b1;
        if ($urandom_range(0, 1) != 0) begin
          write_reg(REG_CENTER, 7'(set_center[p]));
          write_reg(REG_LENGTH, 7'(set_length[p]));
        end else begin
          write_reg(REG_LENGTH, 7'(set_length[p]));
          write_reg(REG_CENTER, 7'(set_center[p]));
        end
      end
      for (int n = 0; n < PER_SET; n++) begin
        if (p == 2 && n == PER_SET / 2) drain_results();
        pick_sample(x, y, user);
        send_sample(x, y, user, 1'b0, '0);
      end
    end

    drain_results();
    repeat (2 * LAT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
src/cmp_pkg.sv
src/cmp_prep.sv
src/cmp_cell.sv
src/cmp_post.sv
src/compass_heading_and_needle_core.sv
bench/compass_heading_and_needle_core_test.sv
